// ----- rtl/rtty_baudot_symbol_encoder_defines.svh -----
// ----------------------------------------------------------------------------
// rtty baudot symbol encoder assertion macros
// shared concurrent assertion forms for the encoder rtl
// ----------------------------------------------------------------------------
`ifndef RTTY_BAUDOT_SYMBOL_ENCODER_DEFINES_SVH
`define RTTY_BAUDOT_SYMBOL_ENCODER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define RBE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define RBE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- rtl/rbe_pkg.sv -----
// ----------------------------------------------------------------------------
// rbe_pkg
// types, codes and the ita2 character map of the rtty baudot symbol encoder
// ----------------------------------------------------------------------------
package rbe_pkg;

	localparam int CHAR_W     = 8;
	localparam int CODE_W     = 5;
	localparam int BIT_TIME_W = 20;
	localparam int DUR_W      = 22;
	localparam int SHIFT_W    = 12;
	localparam int FREQ_W     = 14;
	localparam int REG_IDX_W  = 3;
	localparam int SYM_IDX_W  = 4;

	localparam logic [CODE_W-1:0] CODE_LTRS  = 5'h1F;
	localparam logic [CODE_W-1:0] CODE_FIGS  = 5'h1B;
	localparam logic [CODE_W-1:0] CODE_SPACE = 5'h04;
	localparam logic [CODE_W-1:0] CODE_CR    = 5'h08;
	localparam logic [CODE_W-1:0] CODE_LF    = 5'h02;

	localparam logic [REG_IDX_W-1:0] REG_BIT_TIME  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_STOP_TIME = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CENTER    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REVERSE   = 3'd4;

	localparam logic [BIT_TIME_W-1:0] BIT_TIME_RST  = 20'd22002;
	localparam logic [DUR_W-1:0]      STOP_TIME_RST = 22'd33003;
	localparam logic [SHIFT_W-1:0]    SHIFT_RST     = 12'd170;

	// symbol positions within one seven-symbol frame
	localparam logic [2:0] POS_START = 3'd0;
	localparam logic [2:0] POS_STOP  = 3'd6;
	localparam logic [SYM_IDX_W-1:0] FRAME_LEN    = 4'd7;
	localparam logic [SYM_IDX_W-1:0] LAST_SINGLE  = 4'd6;
	localparam logic [SYM_IDX_W-1:0] LAST_DOUBLE  = 4'd13;

	typedef enum logic [1:0] {
		NEED_ANY,
		NEED_LTRS,
		NEED_FIGS
	} need_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		need_t             need;
	} item_t;

	typedef struct packed {
		logic  mapped;
		item_t item;
	} map_t;

	typedef struct packed {
		logic [BIT_TIME_W-1:0]    bit_time;
		logic [DUR_W-1:0]         stop_time;
		logic signed [FREQ_W-1:0] mark_off;
		logic signed [FREQ_W-1:0] space_off;
	} sym_cfg_t;

	function automatic map_t map_char(input logic [CHAR_W-1:0] ch_in);
		logic [CHAR_W-1:0] ch;
		map_t m;
		ch = ch_in;
		if (ch >= "a" && ch <= "z") begin
			ch = ch - 8'd32;
		end
		m.mapped    = 1'b1;
		m.item.need = NEED_LTRS;
		m.item.code = '0;
		unique case (ch)
			" ": begin m.item.code = CODE_SPACE; m.item.need = NEED_ANY; end
			8'h0D: begin m.item.code = CODE_CR; m.item.need = NEED_ANY; end
			8'h0A: begin m.item.code = CODE_LF; m.item.need = NEED_ANY; end
			"E": m.item.code = 5'd1;
			"A": m.item.code = 5'd3;
			"S": m.item.code = 5'd5;
			"I": m.item.code = 5'd6;
			"U": m.item.code = 5'd7;
			"D": m.item.code = 5'd9;
			"R": m.item.code = 5'd10;
			"J": m.item.code = 5'd11;
			"N": m.item.code = 5'd12;
			"F": m.item.code = 5'd13;
			"C": m.item.code = 5'd14;
			"K": m.item.code = 5'd15;
			"T": m.item.code = 5'd16;
			"Z": m.item.code = 5'd17;
			"L": m.item.code = 5'd18;
			"W": m.item.code = 5'd19;
			"H": m.item.code = 5'd20;
			"Y": m.item.code = 5'd21;
			"P": m.item.code = 5'd22;
			"Q": m.item.code = 5'd23;
			"O": m.item.code = 5'd24;
			"B": m.item.code = 5'd25;
			"G": m.item.code = 5'd26;
			"M": m.item.code = 5'd28;
			"X": m.item.code = 5'd29;
			"V": m.item.code = 5'd30;
			"3": begin m.item.code = 5'd1; m.item.need = NEED_FIGS; end
			"-": begin m.item.code = 5'd3; m.item.need = NEED_FIGS; end
			"'": begin m.item.code = 5'd5; m.item.need = NEED_FIGS; end
			"8": begin m.item.code = 5'd6; m.item.need = NEED_FIGS; end
			"7": begin m.item.code = 5'd7; m.item.need = NEED_FIGS; end
			8'h05: begin m.item.code = 5'd9; m.item.need = NEED_FIGS; end
			"4": begin m.item.code = 5'd10; m.item.need = NEED_FIGS; end
			8'h07: begin m.item.code = 5'd11; m.item.need = NEED_FIGS; end
			",": begin m.item.code = 5'd12; m.item.need = NEED_FIGS; end
			"!": begin m.item.code = 5'd13; m.item.need = NEED_FIGS; end
			":": begin m.item.code = 5'd14; m.item.need = NEED_FIGS; end
			"(": begin m.item.code = 5'd15; m.item.need = NEED_FIGS; end
			"5": begin m.item.code = 5'd16; m.item.need = NEED_FIGS; end
			"+": begin m.item.code = 5'd17; m.item.need = NEED_FIGS; end
			")": begin m.item.code = 5'd18; m.item.need = NEED_FIGS; end
			"2": begin m.item.code = 5'd19; m.item.need = NEED_FIGS; end
			"#": begin m.item.code = 5'd20; m.item.need = NEED_FIGS; end
			"6": begin m.item.code = 5'd21; m.item.need = NEED_FIGS; end
			"0": begin m.item.code = 5'd22; m.item.need = NEED_FIGS; end
			"1": begin m.item.code = 5'd23; m.item.need = NEED_FIGS; end
			"9": begin m.item.code = 5'd24; m.item.need = NEED_FIGS; end
			"?": begin m.item.code = 5'd25; m.item.need = NEED_FIGS; end
			"&": begin m.item.code = 5'd26; m.item.need = NEED_FIGS; end
			".": begin m.item.code = 5'd28; m.item.need = NEED_FIGS; end
			"/": begin m.item.code = 5'd29; m.item.need = NEED_FIGS; end
			"=": begin m.item.code = 5'd30; m.item.need = NEED_FIGS; end
			default: begin
				m.mapped    = 1'b0;
				m.item.need = NEED_ANY;
			end
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/rbe_if.sv -----
// ----------------------------------------------------------------------------
// rbe interfaces
// valid/ready channels for characters, symbols and register writes
// ----------------------------------------------------------------------------
interface rbe_char_if import rbe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface rbe_sym_if import rbe_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [FREQ_W-1:0] freq_offset_half_hz;
	logic [DUR_W-1:0]         duration_us;
	logic                     is_mark;
	logic                     last_symbol;

	modport source (output valid, output freq_offset_half_hz, output duration_us,
		output is_mark, output last_symbol, input ready);
	modport sink (input valid, input freq_offset_half_hz, input duration_us,
		input is_mark, input last_symbol, output ready);
endinterface

interface rbe_cfg_if import rbe_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] reg_index;
	logic [DUR_W-1:0]     wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- rtl/rbe_cfg.sv -----
// ----------------------------------------------------------------------------
// rbe_cfg
// configuration registers and mark/space offset derivation
// ----------------------------------------------------------------------------
module rbe_cfg import rbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rbe_cfg_if.sink    cfg,
	output sym_cfg_t   sym_cfg
);

	logic [BIT_TIME_W-1:0] bit_time_q;
	logic [DUR_W-1:0]      stop_time_q;
	logic [SHIFT_W-1:0]    shift_q;
	logic                  center_q;
	logic                  reverse_q;
	logic                  wr;
	logic [FREQ_W-1:0]     pos;
	logic [FREQ_W-1:0]     neg;
	logic [FREQ_W-1:0]     full;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time_q  <= BIT_TIME_RST;
			stop_time_q <= STOP_TIME_RST;
			shift_q     <= SHIFT_RST;
			center_q    <= 1'b0;
			reverse_q   <= 1'b0;
		end else if (wr) begin
			unique case (cfg.reg_index)
				REG_BIT_TIME:  bit_time_q  <= cfg.wdata[BIT_TIME_W-1:0];
				REG_STOP_TIME: stop_time_q <= cfg.wdata;
				REG_SHIFT:     shift_q     <= cfg.wdata[SHIFT_W-1:0];
				REG_CENTER:    center_q    <= cfg.wdata[0];
				REG_REVERSE:   reverse_q   <= cfg.wdata[0];
				default: ;
			endcase
		end
	end

	// offsets in half-hz
	assign pos  = {{(FREQ_W-SHIFT_W){1'b0}}, shift_q};
	assign neg  = ~pos + 1'b1;
	assign full = {1'b0, shift_q, 1'b0};

	always_comb begin
		sym_cfg.bit_time  = bit_time_q;
		sym_cfg.stop_time = stop_time_q;
		if (center_q) begin
			sym_cfg.mark_off  = reverse_q ? neg : pos;
			sym_cfg.space_off = reverse_q ? pos : neg;
		end else begin
			sym_cfg.mark_off  = reverse_q ? full : '0;
			sym_cfg.space_off = reverse_q ? '0 : full;
		end
	end

endmodule

// ----- rtl/rbe_map.sv -----
// ----------------------------------------------------------------------------
// rbe_map
// input stage: folds case, maps the byte to an ita2 code and holds it
// ----------------------------------------------------------------------------
module rbe_map import rbe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	rbe_char_if.sink char_in,
	input  logic     take,
	output logic     valid_s1,
	output item_t    item_s1
);

	map_t m;
	logic in_xfer;

	assign m             = map_char(char_in.char_code);
	assign char_in.ready = !valid_s1 || take;
	assign in_xfer       = char_in.valid & char_in.ready;

	// unmapped bytes and nul are dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= m.mapped;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= m.item;
		end
	end

endmodule

// ----- rtl/rbe_ser.sv -----
// ----------------------------------------------------------------------------
// rbe_ser
// shift tracking and symbol sequencer with registered symbol output
// ----------------------------------------------------------------------------
module rbe_ser import rbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  item_t      item_s1,
	input  sym_cfg_t   sym_cfg,
	output logic       take,
	rbe_sym_if.source  sym_out
);

	logic                 busy_q;
	logic                 two_q;
	logic                 figs_q;
	logic [SYM_IDX_W-1:0] idx_q;
	logic [CODE_W-1:0]    pre_q;
	logic [CODE_W-1:0]    code_q;
	logic                 out_valid_q;

	logic                 out_adv;
	logic                 at_end;
	logic                 need_pre;
	logic                 second;
	logic [SYM_IDX_W-1:0] pos_w;
	logic [2:0]           pos;
	logic [CODE_W-1:0]    cur;
	logic                 sym_mark;
	logic [DUR_W-1:0]     sym_dur;

	assign out_adv = !out_valid_q || sym_out.ready;
	assign at_end  = idx_q == (two_q ? LAST_DOUBLE : LAST_SINGLE);
	assign take    = valid_s1 && (!busy_q || (out_adv && at_end));

	assign need_pre = (item_s1.need == NEED_LTRS && figs_q)
		|| (item_s1.need == NEED_FIGS && !figs_q);

	// current symbol
	assign second = idx_q >= FRAME_LEN;
	assign pos_w  = second ? idx_q - FRAME_LEN : idx_q;
	assign pos    = pos_w[2:0];
	assign cur    = (two_q && !second) ? pre_q : code_q;

	always_comb begin
		sym_dur = {{(DUR_W-BIT_TIME_W){1'b0}}, sym_cfg.bit_time};
		unique case (pos)
			POS_START: sym_mark = 1'b0;
			3'd1:      sym_mark = cur[0];
			3'd2:      sym_mark = cur[1];
			3'd3:      sym_mark = cur[2];
			3'd4:      sym_mark = cur[3];
			3'd5:      sym_mark = cur[4];
			POS_STOP: begin
				sym_mark = 1'b1;
				sym_dur  = sym_cfg.stop_time;
			end
			default:   sym_mark = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			two_q       <= 1'b0;
			figs_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (busy_q && out_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_adv) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				two_q  <= need_pre;
				if (need_pre) begin
					figs_q <= item_s1.need == NEED_FIGS;
				end
			end else if (busy_q && out_adv) begin
				idx_q <= idx_q + 1'b1;
				if (at_end) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pre_q  <= (item_s1.need == NEED_FIGS) ? CODE_FIGS : CODE_LTRS;
			code_q <= item_s1.code;
		end
		if (busy_q && out_adv) begin
			sym_out.freq_offset_half_hz <= sym_mark ? sym_cfg.mark_off : sym_cfg.space_off;
			sym_out.duration_us         <= sym_dur;
			sym_out.is_mark             <= sym_mark;
			sym_out.last_symbol         <= at_end;
		end
	end

	assign sym_out.valid = out_valid_q;

endmodule

// ----- rtl/rtty_baudot_symbol_encoder.sv -----
// ----------------------------------------------------------------------------
// rtty_baudot_symbol_encoder
// a character passes the map register, the sequencer and the output register
// throughput: one symbol per cycle while ready; 7 symbols per char, 14 with shift
// unmapped bytes and nul are accepted from the input and give no symbols
// the symbol sequencer and its output register set the rate
// reset: async active low, letters shift, registers to defaults, pipeline empty
// ----------------------------------------------------------------------------
`include "rtty_baudot_symbol_encoder_defines.svh"

module rtty_baudot_symbol_encoder import rbe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	rbe_char_if.sink  char_in,
	rbe_sym_if.source sym_out,
	rbe_cfg_if.sink   cfg
);

	sym_cfg_t sym_cfg;
	logic     take;
	logic     valid_s1;
	item_t    item_s1;

	rbe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.sym_cfg (sym_cfg)
	);

	rbe_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_in),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rbe_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.sym_cfg  (sym_cfg),
		.take     (take),
		.sym_out  (sym_out)
	);

	// stop symbol closes every character
	`RBE_ASSERT_SAME(a_last_is_mark, sym_out.valid && sym_out.last_symbol, sym_out.is_mark, "last symbol is not a mark")
	// symbols of one character follow without gaps
	`RBE_ASSERT_NEXT(a_no_gap, sym_out.valid && sym_out.ready && !sym_out.last_symbol, sym_out.valid, "gap inside a character")

endmodule
